// ----- sv/ncf_pkg.sv -----
// ----------------------------------------------------------------------------
// ncf_pkg
// types and constants shared by the negative cycle finder
// ----------------------------------------------------------------------------
package ncf_pkg;

    localparam int VERTEX_W = 6;
    localparam int WEIGHT_W = 32;
    localparam int DIST_W   = 48;

    typedef struct packed {
        logic [VERTEX_W-1:0]        src_vertex;
        logic [VERTEX_W-1:0]        dst_vertex;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       last_edge;
    } edge_item_t;

    typedef struct packed {
        logic                cycle_found;
        logic [VERTEX_W-1:0] vertex;
        logic                last;
    } result_item_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_RD_EDGE,
        ST_RD_DIST,
        ST_RELAX,
        ST_WALK_RD,
        ST_WALK,
        ST_GATH_RD,
        ST_GATH,
        ST_EMIT,
        ST_NONE
    } state_t;

endpackage

// ----- sv/negative_cycle_finder_top.sv -----
// after the last edge the per-vertex memories are cleared for entries 0 to vertex_count, then
// vertex_count - 1 relaxation rounds and one detection round run over the edge list (one edge read, one
// distance read and one relax/write step per edge), then the walk and the answer follow,
// one result item per cycle
// edges load one per cycle; busy is high from the last edge until the final result
// reset: vertex_count is 32, edge list empty; results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
// negative_cycle_finder_top
// bellman-ford negative cycle search over a loaded edge list
// ----------------------------------------------------------------------------
module negative_cycle_finder_top #(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ncf_pkg::edge_item_t   item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [5:0]            cfg_data,
    output logic                  result_valid,
    output ncf_pkg::result_item_t result
);
    import ncf_pkg::*;

    localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC_W = $clog2(MAX_EDGES + 1);
    localparam int VA_W = $clog2(MAX_VERTICES + 1);
    localparam int BA_W = $clog2(MAX_VERTICES + 2);
    localparam int EDGE_W = 2 * VERTEX_W + WEIGHT_W;
    localparam logic signed [DIST_W-1:0] DMAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DMIN = {1'b1, {(DIST_W-1){1'b0}}};

    // memories
    logic [EDGE_W-1:0]        edge_mem [MAX_EDGES];
    logic signed [DIST_W-1:0] dist_mem [MAX_VERTICES + 1];
    logic [VERTEX_W-1:0]      pred_mem [MAX_VERTICES + 1];
    logic [VERTEX_W-1:0]      buf_mem  [MAX_VERTICES + 2];

    state_t state_reg, state_next;
    logic [5:0]    vcount_reg;
    logic [EC_W-1:0] ecount_reg, ecount_next;
    logic [EA_W-1:0] eidx_reg, eidx_next;
    logic [VERTEX_W-1:0] round_reg, round_next;
    logic [VERTEX_W-1:0] nv_reg, nv_next;
    logic          detect_reg, detect_next;
    logic [VERTEX_W-1:0] cur_reg, cur_next;
    logic [VERTEX_W-1:0] c_reg, c_next;
    logic [VERTEX_W:0]   step_reg, step_next;
    logic [BA_W-1:0]     len_reg, len_next;

    // edge read port
    logic [EDGE_W-1:0] erd_reg;
    logic [VERTEX_W-1:0] e_src, e_dst;
    logic signed [WEIGHT_W-1:0] e_w;
    assign e_src = erd_reg[EDGE_W-1 -: VERTEX_W];
    assign e_dst = erd_reg[EDGE_W-VERTEX_W-1 -: VERTEX_W];
    assign e_w   = erd_reg[WEIGHT_W-1:0];

    // dual read of distances, one read of predecessor, one buffer read
    logic signed [DIST_W-1:0] dsrc_reg, ddst_reg;
    logic [VERTEX_W-1:0] prd_reg;
    logic [VERTEX_W-1:0] brd_reg;

    logic [VA_W-1:0] dra, drb, pra, dwa;
    logic dwe, pwe, clr;
    logic [BA_W-1:0] bwa, bra;
    logic bwe;
    logic [VERTEX_W-1:0] bwd;

    logic signed [DIST_W:0] sum;
    logic signed [DIST_W-1:0] cand;
    logic relax, e_ok;
    logic [5:0] nv_clamp;

    assign sum  = $signed({dsrc_reg[DIST_W-1], dsrc_reg}) + (DIST_W+1)'(e_w);
    assign cand = (sum > (DIST_W+1)'(DMAX)) ? DMAX :
                  (sum < (DIST_W+1)'(DMIN)) ? DMIN : sum[DIST_W-1:0];
    assign e_ok = (e_src != '0) && ({1'b0, e_src} <= {1'b0, nv_reg}) &&
                  (e_dst != '0) && ({1'b0, e_dst} <= {1'b0, nv_reg});
    assign relax = e_ok && (ddst_reg > cand);

    assign nv_clamp = (vcount_reg < 6'd2) ? 6'd2 :
                      (32'(vcount_reg) > MAX_VERTICES) ? 6'(MAX_VERTICES) : vcount_reg;

    assign busy      = (state_reg != ST_LOAD);
    assign cfg_ready = (state_reg == ST_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            vcount_reg <= 6'd32;
            ecount_reg <= '0;
            eidx_reg   <= '0;
            round_reg  <= '0;
            nv_reg     <= '0;
            detect_reg <= 1'b0;
            cur_reg    <= '0;
            c_reg      <= '0;
            step_reg   <= '0;
            len_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            if (cfg_valid && cfg_ready)
                vcount_reg <= cfg_data;
            ecount_reg <= ecount_next;
            eidx_reg   <= eidx_next;
            round_reg  <= round_next;
            nv_reg     <= nv_next;
            detect_reg <= detect_next;
            cur_reg    <= cur_next;
            c_reg      <= c_next;
            step_reg   <= step_next;
            len_reg    <= len_next;
        end
    end

    // memory accesses
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD && start && 32'(ecount_reg) < MAX_EDGES)
            edge_mem[ecount_reg[EA_W-1:0]] <= {item.src_vertex, item.dst_vertex, item.weight};
        erd_reg <= edge_mem[eidx_reg];
        if (dwe)
            dist_mem[dwa] <= clr ? '0 : cand;
        if (pwe)
            pred_mem[dwa] <= clr ? '0 : e_src;
        dsrc_reg <= dist_mem[dra];
        ddst_reg <= dist_mem[drb];
        prd_reg  <= pred_mem[pra];
        if (bwe)
            buf_mem[bwa] <= bwd;
        brd_reg <= buf_mem[bra];
    end

    always_comb
    begin
        state_next  = state_reg;
        ecount_next = ecount_reg;
        eidx_next   = eidx_reg;
        round_next  = round_reg;
        nv_next     = nv_reg;
        detect_next = detect_reg;
        cur_next    = cur_reg;
        c_next      = c_reg;
        step_next   = step_reg;
        len_next    = len_reg;
        dra = VA_W'(e_src);
        drb = VA_W'(e_dst);
        pra = VA_W'(cur_reg);
        dwa = VA_W'(e_dst);
        dwe = 1'b0;
        pwe = 1'b0;
        clr = 1'b0;
        bwe = 1'b0;
        bwa = len_reg;
        bwd = cur_reg;
        bra = len_reg;
        result_valid = 1'b0;
        result = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (start)
                begin
                    if (32'(ecount_reg) < MAX_EDGES)
                        ecount_next = ecount_reg + 1'b1;
                    if (item.last_edge)
                    begin
                        nv_next    = nv_clamp;
                        cur_next   = '0;
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR:
            begin
                // clear distance and predecessor, one vertex a cycle
                dwa = VA_W'(cur_reg);
                dwe = 1'b1;
                pwe = 1'b1;
                clr = 1'b1;
                cur_next = cur_reg + 1'b1;
                if (cur_reg == nv_reg)
                begin
                    eidx_next   = '0;
                    round_next  = 6'd1;
                    detect_next = 1'b0;
                    state_next  = (ecount_reg == '0) ? ST_NONE : ST_RD_EDGE;
                    if (ecount_reg != '0 && nv_reg == 6'd1)
                        detect_next = 1'b1;
                end
            end
            ST_RD_EDGE:
                state_next = ST_RD_DIST;
            ST_RD_DIST:
                state_next = ST_RELAX;
            ST_RELAX:
            begin
                if (detect_reg && relax)
                begin
                    cur_next   = e_dst;
                    step_next  = '0;
                    state_next = ST_WALK_RD;
                end
                else
                begin
                    if (relax)
                    begin
                        dwe = 1'b1;
                        pwe = 1'b1;
                    end
                    state_next = ST_RD_EDGE;
                    if (32'(eidx_reg) + 1 >= 32'(ecount_reg))
                    begin
                        eidx_next = '0;
                        if (detect_reg)
                            state_next = ST_NONE;
                        else if (round_reg + 1'b1 >= nv_reg)
                            detect_next = 1'b1;
                        else
                            round_next = round_reg + 1'b1;
                    end
                    else
                        eidx_next = eidx_reg + 1'b1;
                end
            end
            ST_WALK_RD:
                state_next = ST_WALK;
            ST_WALK:
            begin
                if (step_reg == {1'b0, nv_reg})
                begin
                    // cur is the cycle start: store it, then follow predecessors
                    c_next     = cur_reg;
                    bwa        = '0;
                    bwe        = 1'b1;
                    len_next   = BA_W'(1);
                    step_next  = '0;
                    state_next = ST_GATH_RD;
                end
                else
                begin
                    cur_next   = prd_reg;
                    step_next  = step_reg + 1'b1;
                    state_next = ST_WALK_RD;
                end
            end
            ST_GATH_RD:
                state_next = ST_GATH;
            ST_GATH:
            begin
                // prd_reg is pred(cur)
                bwa = len_reg;
                bwe = 1'b1;
                len_next = len_reg + 1'b1;
                if (step_reg < {1'b0, nv_reg} && prd_reg != c_reg)
                begin
                    bwd        = prd_reg;
                    cur_next   = prd_reg;
                    step_next  = step_reg + 1'b1;
                    state_next = ST_GATH_RD;
                end
                else
                begin
                    bwd        = c_reg;
                    state_next = ST_EMIT;
                end
                bra = len_reg;
            end
            ST_EMIT:
            begin
                // buffer read issued with len - 1; once primed, the data is valid for index len
                bra = len_reg - 1'b1;
                if (len_reg != '0 && step_reg[VERTEX_W])
                begin
                    result_valid       = 1'b1;
                    result.cycle_found = 1'b1;
                    result.vertex      = brd_reg;
                    result.last        = (len_reg == '0) ? 1'b1 : 1'b0;
                end
                // step msb marks the first read as primed
                if (!step_reg[VERTEX_W])
                begin
                    step_next = {1'b1, {VERTEX_W{1'b0}}};
                    len_next  = len_reg - 1'b1;
                end
                else if (len_reg == '0)
                begin
                    result_valid       = 1'b1;
                    result.cycle_found = 1'b1;
                    result.vertex      = brd_reg;
                    result.last        = 1'b1;
                    ecount_next        = '0;
                    state_next         = ST_LOAD;
                end
                else
                    len_next = len_reg - 1'b1;
            end
            ST_NONE:
            begin
                result_valid       = 1'b1;
                result.cycle_found = 1'b0;
                result.vertex      = '0;
                result.last        = 1'b1;
                ecount_next        = '0;
                state_next         = ST_LOAD;
            end
            default:
                state_next = ST_LOAD;
        endcase

        if (state_reg == ST_RD_EDGE)
        begin
            dra = VA_W'(e_src);
            drb = VA_W'(e_dst);
        end
    end

endmodule
